// ----- hdl/button_press_classifier_assert.svh -----
// Assertion macros shared by the classifier checker.
// No dependencies; include by bare file name.
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BPC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live through reset
`define BPC_ASSERT_NEXT_ANY(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bpc_pkg.sv -----
// Types and constants for the button press classifier.
// No dependencies.
`timescale 1ns / 1ps

package bpc_pkg;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_DOWN = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_LONG = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SHORT  = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_LONG   = 2'd2
    } kind_t;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_DEBOUNCE = 3'd0;
    localparam logic [2:0] REG_LONG_MS  = 3'd1;
    localparam logic [2:0] REG_GAP_MS   = 3'd2;
    localparam logic [2:0] REG_SHORT_EN = 3'd3;
    localparam logic [2:0] REG_DOUBLE_EN = 3'd4;
    localparam logic [2:0] REG_LONG_EN  = 3'd5;

    localparam logic [3:0]  DEBOUNCE_RESET = 4'd3;
    localparam logic [15:0] LONG_MS_RESET  = 16'd800;
    localparam logic [15:0] GAP_MS_RESET   = 16'd300;

    localparam int PADDR_W = 5;

    typedef struct packed {
        logic [3:0]  debounce_count;
        logic [15:0] long_press_ms;
        logic [15:0] double_gap_ms;
        logic [15:0] short_mask;
        logic [15:0] double_mask;
        logic [15:0] long_mask;
    } cfg_t;

    // one per-button entry of the state memory
    typedef struct packed {
        logic [31:0] release_time;
        logic [31:0] press_time;
        phase_t      phase;
        logic [3:0]  count;
        logic        last;
        logic        stable;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        release_time: 32'd0,
        press_time:   32'd0,
        phase:        PH_IDLE,
        count:        4'd0,
        last:         1'b0,
        stable:       1'b0
    };

    typedef struct packed {
        logic  fire;
        kind_t kind;
    } press_t;

endpackage

// ----- hdl/bpc_apb_regs.sv -----
// APB configuration registers of the button press classifier.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_apb_regs
    import bpc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_DEBOUNCE:  cfg_next.debounce_count = pwdata[3:0];
                REG_LONG_MS:   cfg_next.long_press_ms  = pwdata[15:0];
                REG_GAP_MS:    cfg_next.double_gap_ms  = pwdata[15:0];
                REG_SHORT_EN:  cfg_next.short_mask     = pwdata[15:0];
                REG_DOUBLE_EN: cfg_next.double_mask    = pwdata[15:0];
                REG_LONG_EN:   cfg_next.long_mask      = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_count <= DEBOUNCE_RESET;
            cfg_reg.long_press_ms  <= LONG_MS_RESET;
            cfg_reg.double_gap_ms  <= GAP_MS_RESET;
            cfg_reg.short_mask     <= 16'd0;
            cfg_reg.double_mask    <= 16'd0;
            cfg_reg.long_mask      <= 16'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEBOUNCE:  prdata = {28'd0, cfg_reg.debounce_count};
            REG_LONG_MS:   prdata = {16'd0, cfg_reg.long_press_ms};
            REG_GAP_MS:    prdata = {16'd0, cfg_reg.double_gap_ms};
            REG_SHORT_EN:  prdata = {16'd0, cfg_reg.short_mask};
            REG_DOUBLE_EN: prdata = {16'd0, cfg_reg.double_mask};
            REG_LONG_EN:   prdata = {16'd0, cfg_reg.long_mask};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

// ----- hdl/bpc_state_ram.sv -----
// Per-button state memory: registered read, valid bits, write bypass.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_state_ram
    import bpc_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_entry,
    output entry_t        rd_entry
);

    entry_t             mem [DEPTH];
    entry_t             rdata_reg;
    entry_t             byp_reg;
    logic               byp_hit_reg;
    logic               rvalid_reg;
    logic [DEPTH-1:0]   valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // entry being written while read: the read sees the old word, so keep the new one
    always_ff @(posedge aclk) begin
        if (rd_en && wr_en && (wr_addr == rd_addr)) begin
            byp_reg <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            byp_hit_reg <= 1'b0;
            rvalid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                byp_hit_reg <= wr_en && (wr_addr == rd_addr);
                rvalid_reg  <= valid_reg[rd_addr];
            end
        end
    end

    always_comb begin
        priority if (byp_hit_reg) begin
            rd_entry = byp_reg;
        end else if (rvalid_reg) begin
            rd_entry = rdata_reg;
        end else begin
            rd_entry = ENTRY_RESET;
        end
    end

endmodule

// ----- hdl/bpc_update.sv -----
// Debounce and press-phase update for one button entry.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_update
    import bpc_pkg::*;
(
    input  cfg_t        cfg,
    input  entry_t      cur,
    input  logic [3:0]  idx,
    input  logic        raw,
    input  logic [31:0] now,
    output entry_t      nxt,
    output press_t      press
);

    logic        settled;
    logic        changed;
    logic        in_wait;
    logic [31:0] base;
    logic [15:0] limit;
    logic [31:0] elapsed;
    logic        timeout;
    logic        short_en;
    logic        double_en;
    logic        long_en;

    assign in_wait   = (cur.phase == PH_WAIT);
    assign base      = in_wait ? cur.release_time : cur.press_time;
    assign limit     = in_wait ? cfg.double_gap_ms : cfg.long_press_ms;
    assign elapsed   = now - base;
    assign timeout   = (elapsed >= {16'd0, limit});
    assign short_en  = cfg.short_mask[idx];
    assign double_en = cfg.double_mask[idx];
    assign long_en   = cfg.long_mask[idx];

    always_comb begin
        nxt   = cur;
        press = '{fire: 1'b0, kind: KIND_SHORT};

        if (raw == cur.last) begin
            if (cur.count < cfg.debounce_count) begin
                nxt.count = cur.count + 4'd1;
            end
        end else begin
            nxt.last  = raw;
            nxt.count = 4'd1;
        end

        settled = (nxt.count >= cfg.debounce_count);
        changed = settled && (raw != cur.stable);
        if (changed) begin
            nxt.stable = raw;
        end

        unique case (cur.phase)
            PH_IDLE: begin
                if (changed && nxt.stable) begin
                    nxt.phase      = PH_DOWN;
                    nxt.press_time = now;
                end
            end
            PH_DOWN: begin
                if (changed && !nxt.stable) begin
                    nxt.release_time = now;
                    if (double_en) begin
                        nxt.phase = PH_WAIT;
                    end else begin
                        press     = '{fire: short_en, kind: KIND_SHORT};
                        nxt.phase = PH_IDLE;
                    end
                end else if (nxt.stable && timeout) begin
                    press     = '{fire: long_en, kind: KIND_LONG};
                    nxt.phase = PH_LONG;
                end
            end
            PH_WAIT: begin
                if (changed && nxt.stable) begin
                    press     = '{fire: double_en, kind: KIND_DOUBLE};
                    nxt.phase = PH_LONG;
                end else if (timeout) begin
                    press     = '{fire: short_en, kind: KIND_SHORT};
                    nxt.phase = PH_IDLE;
                end
            end
            PH_LONG: begin
                if (changed && !nxt.stable) begin
                    nxt.phase = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- hdl/button_press_classifier.sv -----
// Top level of the button press classifier: stream ports, APB, pipeline.
// Depends on bpc_pkg, bpc_apb_regs, bpc_state_ram, bpc_update.
`timescale 1ns / 1ps

// Button press classifier. Each s_ beat is one poll sample of one button
// (index, raw level, millisecond time stamp); the block debounces the level
// per button and reports short, double and long presses as m_ beats, at most
// one per sample. Samples are taken one per clock while the input is not
// held off: a beat is registered into the sample stage as the per-button
// state memory is read, then the sample stage updates the entry, writes it
// back and loads the result register. Back-to-back samples for
// the same button are served by a write bypass around the memory. The input
// holds off only when a sample that raises a press meets a press beat still
// waiting on m_tready. Samples for buttons at or above BUTTONS are dropped.
// State starts cleared after reset through per-entry valid bits, so no
// clearing pass is needed. Configure only while no samples are in flight.

module button_press_classifier
    import bpc_pkg::*;
#(
    parameter int BUTTONS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // sample input
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [39:0]        s_tdata,   // [3:0] button_index, [4] raw_pressed,
                                          // [36:5] now_ms, [39:37] zero
    // press output
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [3:0] press_button, [7:4] zero
    output logic [1:0]         m_tuser,   // [1:0] press_kind
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // the 4-bit index reaches at most 16 entries
    localparam int DEPTH = (BUTTONS < 16) ? BUTTONS : 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfg_t        cfg;
    entry_t      cur_entry;
    entry_t      nxt_entry;
    press_t      press;

    logic [3:0]  s_idx;
    logic        s_in_range;
    logic        accept;

    // sample stage
    logic        s1_valid_reg, s1_valid_next;
    logic [3:0]  s1_idx_reg;
    logic        s1_raw_reg;
    logic [31:0] s1_now_reg;
    logic        s1_live_reg;
    logic        s1_stall;
    logic        s1_go;
    logic        wr_en;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [3:0]  m_button_reg;
    kind_t       m_kind_reg;

    assign s_idx      = s_tdata[3:0];
    assign s_in_range = (int'(s_idx) < BUTTONS);
    assign accept     = s_tvalid & s_tready;

    bpc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpc_state_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (s_idx[AW-1:0]),
        .wr_en    (wr_en),
        .wr_addr  (s1_idx_reg[AW-1:0]),
        .wr_entry (nxt_entry),
        .rd_entry (cur_entry)
    );

    bpc_update u_upd (
        .cfg   (cfg),
        .cur   (cur_entry),
        .idx   (s1_idx_reg),
        .raw   (s1_raw_reg),
        .now   (s1_now_reg),
        .nxt   (nxt_entry),
        .press (press)
    );

    // a press can only leave when the result register is free or emptying
    assign s1_stall = s1_valid_reg & s1_live_reg & press.fire & m_valid_reg & ~m_tready;
    assign s1_go    = s1_valid_reg & ~s1_stall;
    assign wr_en    = s1_go & s1_live_reg;
    assign s_tready = ~s1_stall;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (wr_en && press.fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_idx_reg  <= s_idx;
            s1_raw_reg  <= s_tdata[4];
            s1_now_reg  <= s_tdata[36:5];
            s1_live_reg <= s_in_range;
        end
        if (wr_en && press.fire) begin
            m_button_reg <= s1_idx_reg;
            m_kind_reg   <= press.kind;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_button_reg};
    assign m_tuser  = m_kind_reg;

endmodule

// ----- hdl/bpc_checker.sv -----
// Port-level checker for the button press classifier, with its bind.
// Depends on button_press_classifier_assert.svh.
`timescale 1ns / 1ps
`include "button_press_classifier_assert.svh"

module bpc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    `BPC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "press beat changed while stalled")
    `BPC_ASSERT_NOW(a_kind_range, aclk, aresetn, m_tvalid, m_tuser != 2'd3, "undefined press kind")
    `BPC_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[7:4] == 4'd0, "tdata padding not zero")
    `BPC_ASSERT_NEXT_ANY(a_reset_empty, aclk, !aresetn, !m_tvalid && s_tready, "pipeline not empty after reset")

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
